// ===== rtl/core/dgsp_pkg.sv =====
package dgsp_pkg;

    localparam int NodeCount  = 64;
    localparam int EdgeSlots  = 1024;
    localparam int WeightBits = 16;
    localparam int NodeBits   = 6;
    localparam int SlotBits   = 10;
    localparam int DistBits   = 22;
    localparam logic [DistBits-1:0] DistMax = '1;

    localparam logic [2:0] ReqLoad    = 3'd0;
    localparam logic [2:0] ReqInsert  = 3'd1;
    localparam logic [2:0] ReqDelete  = 3'd2;
    localparam logic [2:0] ReqCompute = 3'd3;
    localparam logic [2:0] ReqRead    = 3'd4;

    localparam logic [1:0] StDone   = 2'd0;
    localparam logic [1:0] StFull   = 2'd1;
    localparam logic [1:0] StExists = 2'd2;

    // edge word: valid, tail, head, cost
    localparam int EdgeBits = 1 + 2 * NodeBits + WeightBits;
    // node word: distance, reached, pred valid, pred, settled
    localparam int NodeWordBits = DistBits + 3 + NodeBits;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [5:0]  from_node;
        logic [5:0]  to_node;
        logic [15:0] edge_weight;
        logic [5:0]  query_node;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [21:0] distance;
        logic        reachable;
        logic        has_parent;
        logic [5:0]  parent_node;
        logic        affected;
    } rsp_t;

    typedef struct packed {
        logic                  valid;
        logic [NodeBits-1:0]   tail;
        logic [NodeBits-1:0]   head;
        logic [WeightBits-1:0] cost;
    } edge_t;

    typedef struct packed {
        logic [DistBits-1:0] path_len;
        logic                reached;
        logic                has_pred;
        logic [NodeBits-1:0] pred;
        logic                settled;
    } node_t;

endpackage

// ===== rtl/core/dgsp_ram.sv =====
module dgsp_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/dynamic_graph_shortest_paths.sv =====
// channel  | direction | signals
// request  | in        | start, busy, req
// result   | out       | done, rsp
// config   | in        | cfg_valid, cfg_ready, cfg_data
// load, insert and delete scan the 1024-slot edge table one slot a cycle
// for every request, done follows the last busy cycle
// compute clears 64 node words, then per settled node a minimum search and an
// edge sweep, plus one last search that finds no node left
// after reset a clearing pass of both memories keeps busy high
// results cannot be stalled
module dynamic_graph_shortest_paths
    import dgsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        req,
    output logic        done,
    output rsp_t        rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN, S_SCAN_LAST, S_CLR, S_MIN, S_MIN_LAST, S_REL_RD,
        S_REL_HEAD, S_REL_NODE, S_READ, S_READ2, S_OUT
    } state_t;

    state_t state_reg;
    req_t   req_reg;
    rsp_t   rsp_reg;
    logic   done_reg;
    logic [NodeBits-1:0] src_reg;
    logic [NodeCount-1:0] touched_reg;
    logic [SlotBits:0] cnt_reg;
    logic              found_reg;
    logic              free_found_reg;
    logic [SlotBits-1:0] free_reg;
    logic [NodeBits:0] best_reg;
    logic [DistBits-1:0] best_dist_reg;
    logic [NodeBits-1:0] best_pred_reg;
    logic                best_has_pred_reg;
    logic [NodeBits-1:0] u_reg;
    logic [DistBits-1:0] u_dist_reg;
    logic [DistBits-1:0] nd_reg;

    // edge memory
    logic                e_we;
    logic [SlotBits-1:0] e_waddr, e_raddr;
    edge_t               e_wdata, e_rd;
    logic [EdgeBits-1:0] e_rraw;
    // node memory
    logic                n_we;
    logic [NodeBits-1:0] n_waddr, n_raddr;
    node_t               n_wdata, n_rdata;
    logic [NodeWordBits-1:0] n_rraw;

    dgsp_ram #(.Width(EdgeBits), .Depth(EdgeSlots)) u_edge (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rraw)
    );

    dgsp_ram #(.Width(NodeWordBits), .Depth(NodeCount)) u_node (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(n_raddr), .rdata(n_rraw)
    );

    assign n_rdata = node_t'(n_rraw);
    assign e_rd    = edge_t'(e_rraw);

    // slot read in the previous cycle
    logic [SlotBits-1:0] prev_slot;
    assign prev_slot = cnt_reg[SlotBits-1:0] - 1'b1;
    logic prev_match;
    assign prev_match = e_rd.valid && e_rd.tail == req_reg.from_node
                        && e_rd.head == req_reg.to_node;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;

    logic [DistBits:0] sum;
    assign sum = {1'b0, u_dist_reg} + {{(DistBits+1-WeightBits){1'b0}}, e_rd.cost};

    always_comb
    begin
        e_we          = 1'b0;
        e_waddr       = free_reg;
        e_wdata.valid = 1'b1;
        e_wdata.tail  = req_reg.from_node;
        e_wdata.head  = req_reg.to_node;
        e_wdata.cost  = req_reg.edge_weight;
        e_raddr       = cnt_reg[SlotBits-1:0];
        n_we          = 1'b0;
        n_waddr       = cnt_reg[NodeBits-1:0];
        n_wdata       = '0;
        n_raddr       = cnt_reg[NodeBits-1:0];
        unique case (state_reg)
            S_INIT:
            begin
                e_we    = 1'b1;
                e_waddr = cnt_reg[SlotBits-1:0];
                e_wdata = '0;
                n_we    = 1'b1;
            end
            S_IDLE:     n_raddr = req.query_node;
            S_SCAN, S_SCAN_LAST:
            begin
                if (req_reg.req_type == ReqDelete && cnt_reg != '0 && prev_match)
                begin
                    e_we    = 1'b1;
                    e_waddr = prev_slot;
                    e_wdata = '0;
                end
            end
            S_CLR:      n_we = 1'b1;
            S_MIN_LAST:
            begin
                if (!best_reg[NodeBits])
                begin
                    n_we             = 1'b1;
                    n_waddr          = best_reg[NodeBits-1:0];
                    n_wdata.path_len = best_dist_reg;
                    n_wdata.reached  = 1'b1;
                    n_wdata.has_pred = best_has_pred_reg;
                    n_wdata.pred     = best_pred_reg;
                    n_wdata.settled  = 1'b1;
                end
            end
            S_REL_HEAD: n_raddr = e_rd.head;
            S_REL_NODE:
            begin
                // edge address held since the head read, so e_rd is still this slot
                e_raddr          = cnt_reg[SlotBits-1:0] + 1'b1;
                n_waddr          = e_rd.head;
                n_wdata.path_len = nd_reg;
                n_wdata.reached  = 1'b1;
                n_wdata.has_pred = 1'b1;
                n_wdata.pred     = u_reg;
                n_wdata.settled  = 1'b0;
                n_we = e_rd.valid && e_rd.tail == u_reg && !n_rdata.settled
                       && (!n_rdata.reached || nd_reg < n_rdata.path_len);
            end
            S_READ:     n_raddr = req_reg.query_node;
            S_OUT:
            begin
                if ((req_reg.req_type == ReqLoad
                     || (req_reg.req_type == ReqInsert && !found_reg))
                    && free_found_reg)
                begin
                    e_we = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_INIT;
            done_reg          <= 1'b0;
            src_reg           <= 6'd1;
            touched_reg       <= '0;
            cnt_reg           <= '0;
            found_reg         <= 1'b0;
            free_found_reg    <= 1'b0;
            free_reg          <= '0;
            best_reg          <= '0;
            best_dist_reg     <= '0;
            best_pred_reg     <= '0;
            best_has_pred_reg <= 1'b0;
            u_reg             <= '0;
            u_dist_reg        <= '0;
            nd_reg            <= '0;
            req_reg           <= '0;
            rsp_reg           <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                src_reg <= cfg_data;
            end
            unique case (state_reg)
                S_INIT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (SlotBits+1)'(EdgeSlots - 1))
                    begin
                        cnt_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg <= req;
                        rsp_reg <= '0;
                        cnt_reg <= '0;
                        found_reg <= 1'b0;
                        free_found_reg <= 1'b0;
                        unique case (req.req_type)
                            ReqLoad, ReqInsert, ReqDelete: state_reg <= S_SCAN;
                            ReqCompute: state_reg <= S_CLR;
                            ReqRead: state_reg <= S_READ;
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_SCAN, S_SCAN_LAST:
                begin
                    if (cnt_reg != '0)
                    begin
                        if (prev_match)
                        begin
                            found_reg <= 1'b1;
                        end
                        if (!e_rd.valid && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_reg <= prev_slot;
                        end
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (state_reg == S_SCAN && cnt_reg == (SlotBits+1)'(EdgeSlots - 1))
                    begin
                        state_reg <= S_SCAN_LAST;
                    end
                    else if (state_reg == S_SCAN_LAST)
                    begin
                        state_reg <= S_OUT;
                        cnt_reg <= '0;
                    end
                end
                S_CLR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (SlotBits+1)'(NodeCount - 1))
                    begin
                        state_reg <= S_MIN;
                        cnt_reg <= '0;
                        best_reg <= {1'b1, {NodeBits{1'b0}}};
                    end
                end
                S_MIN, S_MIN_LAST:
                begin
                    // the source counts as reached before it is settled
                    if (state_reg == S_MIN && cnt_reg != '0)
                    begin
                        if ((n_rdata.reached || prev_slot[NodeBits-1:0] == src_reg)
                            && !n_rdata.settled
                            && (best_reg[NodeBits] || n_rdata.path_len < best_dist_reg))
                        begin
                            best_reg <= {1'b0, prev_slot[NodeBits-1:0]};
                            best_dist_reg <= n_rdata.path_len;
                            best_pred_reg <= n_rdata.pred;
                            best_has_pred_reg <= n_rdata.has_pred;
                        end
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (state_reg == S_MIN && cnt_reg == (SlotBits+1)'(NodeCount))
                    begin
                        state_reg <= S_MIN_LAST;
                    end
                    if (state_reg == S_MIN_LAST)
                    begin
                        if (best_reg[NodeBits])
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            u_reg <= best_reg[NodeBits-1:0];
                            u_dist_reg <= best_dist_reg;
                            cnt_reg <= '0;
                            state_reg <= S_REL_RD;
                        end
                    end
                end
                S_REL_RD:
                begin
                    state_reg <= S_REL_HEAD;
                end
                S_REL_HEAD:
                begin
                    nd_reg <= sum[DistBits] ? DistMax : sum[DistBits-1:0];
                    state_reg <= S_REL_NODE;
                end
                S_REL_NODE:
                begin
                    if (cnt_reg == (SlotBits+1)'(EdgeSlots - 1))
                    begin
                        cnt_reg <= '0;
                        best_reg <= {1'b1, {NodeBits{1'b0}}};
                        state_reg <= S_MIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        state_reg <= S_REL_HEAD;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_READ2;
                end
                S_READ2:
                begin
                    if (n_rdata.reached)
                    begin
                        rsp_reg.distance  <= n_rdata.path_len;
                        rsp_reg.reachable <= 1'b1;
                    end
                    rsp_reg.has_parent  <= n_rdata.has_pred;
                    rsp_reg.parent_node <= n_rdata.has_pred ? n_rdata.pred : '0;
                    rsp_reg.affected    <= touched_reg[req_reg.query_node];
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (req_reg.req_type == ReqLoad || req_reg.req_type == ReqInsert)
                    begin
                        if (req_reg.req_type == ReqInsert && found_reg)
                        begin
                            rsp_reg.status <= StExists;
                        end
                        else if (!free_found_reg)
                        begin
                            rsp_reg.status <= StFull;
                        end
                        else if (req_reg.req_type == ReqInsert)
                        begin
                            touched_reg[req_reg.from_node] <= 1'b1;
                            touched_reg[req_reg.to_node] <= 1'b1;
                        end
                    end
                    if (req_reg.req_type == ReqDelete)
                    begin
                        touched_reg[req_reg.from_node] <= 1'b1;
                        touched_reg[req_reg.to_node] <= 1'b1;
                    end
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== dv/tb_dynamic_graph_shortest_paths.sv =====
module tb_dynamic_graph_shortest_paths;
    import dgsp_pkg::*;

    class path_tracker;
        bit                  slot_used [EdgeSlots];
        logic [5:0]          slot_tail [EdgeSlots];
        logic [5:0]          slot_head [EdgeSlots];
        logic [15:0]         slot_cost [EdgeSlots];
        logic [DistBits-1:0] path_len  [NodeCount];
        bit                  reached   [NodeCount];
        bit                  has_pred  [NodeCount];
        logic [5:0]          pred      [NodeCount];
        bit                  settled   [NodeCount];
        bit                  touched   [NodeCount];
        logic [5:0]          source;
        rsp_t                pending [$];
        int                  edge_count;
        int                  errors;
        int                  items;
        int                  results;
        int                  full_hits;
        int                  exist_hits;

        function new();
            source = 6'd1;
            for (int i = 0; i < EdgeSlots; i++) slot_used[i] = 0;
            for (int n = 0; n < NodeCount; n++)
            begin
                path_len[n] = '0;
                reached[n] = 0;
                has_pred[n] = 0;
                pred[n] = '0;
                settled[n] = 0;
                touched[n] = 0;
            end
        endfunction

        // lowest free slot, status full when none left
        function logic [1:0] append_edge(logic [5:0] a, logic [5:0] b, logic [15:0] w);
            for (int i = 0; i < EdgeSlots; i++)
            begin
                if (!slot_used[i])
                begin
                    slot_used[i] = 1;
                    slot_tail[i] = a;
                    slot_head[i] = b;
                    slot_cost[i] = w;
                    edge_count++;
                    return StDone;
                end
            end
            return StFull;
        endfunction

        function void find_paths();
            int u;
            int nd;
            int v;
            for (int n = 0; n < NodeCount; n++)
            begin
                path_len[n] = '0;
                reached[n] = 0;
                has_pred[n] = 0;
                settled[n] = 0;
            end
            reached[source] = 1;
            forever
            begin
                u = -1;
                for (int n = 0; n < NodeCount; n++)
                    if (reached[n] && !settled[n] && (u < 0 || path_len[n] < path_len[u]))
                        u = n;
                if (u < 0)
                    break;
                settled[u] = 1;
                for (int i = 0; i < EdgeSlots; i++)
                begin
                    if (!slot_used[i] || slot_tail[i] != u)
                        continue;
                    v = slot_head[i];
                    if (settled[v])
                        continue;
                    nd = int'(path_len[u]) + int'(slot_cost[i]);
                    if (nd > int'(DistMax))
                        nd = int'(DistMax);
                    if (!reached[v] || nd < int'(path_len[v]))
                    begin
                        path_len[v] = nd[DistBits-1:0];
                        reached[v] = 1;
                        has_pred[v] = 1;
                        pred[v] = u[5:0];
                    end
                end
            end
        endfunction

        function void note_request(req_t r);
            rsp_t e;
            bit found;
            e = '0;
            found = 0;
            items++;
            case (r.req_type)
                ReqLoad:
                begin
                    e.status = append_edge(r.from_node, r.to_node, r.edge_weight);
                end
                ReqInsert:
                begin
                    for (int i = 0; i < EdgeSlots; i++)
                        if (slot_used[i] && slot_tail[i] == r.from_node
                            && slot_head[i] == r.to_node)
                            found = 1;
                    if (found)
                        e.status = StExists;
                    else
                    begin
                        e.status = append_edge(r.from_node, r.to_node, r.edge_weight);
                        if (e.status == StDone)
                        begin
                            touched[r.from_node] = 1;
                            touched[r.to_node] = 1;
                        end
                    end
                end
                ReqDelete:
                begin
                    for (int i = 0; i < EdgeSlots; i++)
                        if (slot_used[i] && slot_tail[i] == r.from_node
                            && slot_head[i] == r.to_node)
                        begin
                            slot_used[i] = 0;
                            edge_count--;
                        end
                    touched[r.from_node] = 1;
                    touched[r.to_node] = 1;
                end
                ReqCompute:
                begin
                    find_paths();
                end
                ReqRead:
                begin
                    if (reached[r.query_node])
                    begin
                        e.distance = path_len[r.query_node];
                        e.reachable = 1;
                    end
                    if (has_pred[r.query_node])
                    begin
                        e.has_parent = 1;
                        e.parent_node = pred[r.query_node];
                    end
                    e.affected = touched[r.query_node];
                end
                default: ;
            endcase
            if (e.status == StFull) full_hits++;
            if (e.status == StExists) exist_hits++;
            pending = {pending, e};
        endfunction

        function void check_result(rsp_t a);
            rsp_t e;
            if (pending.size() == 0)
            begin
                $error("result with nothing expected: %p", a);
                errors++;
                return;
            end
            e = pending.pop_front();
            results++;
            if (a.status !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, a.status);
                errors++;
            end
            if (a.distance !== e.distance)
            begin
                $error("distance: expected %0d, got %0d", e.distance, a.distance);
                errors++;
            end
            if (a.reachable !== e.reachable)
            begin
                $error("reachable: expected %0d, got %0d", e.reachable, a.reachable);
                errors++;
            end
            if (a.has_parent !== e.has_parent)
            begin
                $error("has_parent: expected %0d, got %0d", e.has_parent, a.has_parent);
                errors++;
            end
            if (a.parent_node !== e.parent_node)
            begin
                $error("parent_node: expected %0d, got %0d", e.parent_node, a.parent_node);
                errors++;
            end
            if (a.affected !== e.affected)
            begin
                $error("affected: expected %0d, got %0d", e.affected, a.affected);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    req_t       req;
    logic       done;
    rsp_t       rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [5:0] cfg_data;

    path_tracker sb = new();
    bit          use_gaps;

    dynamic_graph_shortest_paths dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(rsp);
    end

    task automatic pause();
        int x;
        int n;
        x = $urandom_range(0, 99);
        n = 0;
        if (use_gaps)
        begin
            if (x >= 90)
                n = $urandom_range(10, 60);
            else if (x >= 50)
                n = $urandom_range(1, 3);
        end
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send(req_t r);
        start <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(r);
        pause();
    endtask

    function automatic req_t make(logic [2:0] t, logic [5:0] a, logic [5:0] b,
                                  logic [15:0] w, logic [5:0] q);
        req_t r;
        r.req_type = t;
        r.from_node = a;
        r.to_node = b;
        r.edge_weight = w;
        r.query_node = q;
        return r;
    endfunction

    // source may only change once the block has drained
    task automatic set_source(logic [5:0] s);
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= s;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.source = s;
    endtask

    function automatic logic [5:0] pick_node();
        return ($urandom_range(0, 99) < 80) ? 6'($urandom_range(0, 15)) : 6'($urandom);
    endfunction

    function automatic req_t random_request();
        req_t r;
        int   k;
        r = '0;
        r.edge_weight = 16'($urandom);
        k = $urandom_range(0, 99);
        r.from_node = pick_node();
        r.to_node = pick_node();
        if ($urandom_range(0, 99) < 70)
            r.edge_weight = 16'($urandom_range(0, 255));
        r.query_node = pick_node();
        if (k < 22)
            r.req_type = ReqLoad;
        else if (k < 44)
            r.req_type = ReqInsert;
        else if (k < 56)
            r.req_type = ReqDelete;
        else if (k < 59)
            r.req_type = ReqCompute;
        else if (k < 97)
            r.req_type = ReqRead;
        else
            r.req_type = 3'($urandom_range(5, 7));
        return r;
    endfunction

    initial
    begin
        logic [5:0] sources [5];
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        use_gaps = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: parallel edges, ties, duplicates, absent delete, extremes
        set_source(6'd0);
        send(make(ReqRead, 6'd0, 6'd0, 16'd0, 6'd5));
        send(make(ReqInsert, 6'd0, 6'd1, 16'd5, 6'd0));
        send(make(ReqLoad, 6'd0, 6'd1, 16'd3, 6'd0));
        send(make(ReqInsert, 6'd1, 6'd2, 16'd0, 6'd0));
        send(make(ReqInsert, 6'd0, 6'd2, 16'd3, 6'd0));
        send(make(ReqLoad, 6'd2, 6'd63, 16'hFFFF, 6'd0));
        send(make(ReqInsert, 6'd63, 6'd0, 16'd1, 6'd0));
        send(make(ReqInsert, 6'd0, 6'd1, 16'd9, 6'd0));
        send(make(ReqDelete, 6'd10, 6'd11, 16'd0, 6'd0));
        send(make(ReqCompute, 6'd0, 6'd0, 16'd0, 6'd0));
        send(make(ReqRead, 6'd0, 6'd0, 16'd0, 6'd0));
        send(make(ReqRead, 6'd0, 6'd0, 16'd0, 6'd1));
        send(make(ReqRead, 6'd0, 6'd0, 16'd0, 6'd2));
        send(make(ReqRead, 6'd0, 6'd0, 16'd0, 6'd63));
        send(make(ReqRead, 6'd0, 6'd0, 16'd0, 6'd10));
        send(make(ReqDelete, 6'd0, 6'd1, 16'd0, 6'd0));
        send(make(ReqCompute, 6'd0, 6'd0, 16'd0, 6'd0));
        send(make(ReqRead, 6'd0, 6'd0, 16'd0, 6'd1));
        send(make(ReqRead, 6'd0, 6'd0, 16'd0, 6'd2));
        send(make(3'd5, 6'd0, 6'd0, 16'd0, 6'd0));
        send(make(3'd7, 6'h3F, 6'h3F, 16'hFFFF, 6'h3F));
        send(make(ReqRead, 6'd0, 6'd0, 16'd0, 6'd63));

        sources[0] = 6'd1;
        sources[1] = 6'd63;
        sources[2] = 6'd0;
        sources[3] = 6'($urandom_range(0, 15));
        sources[4] = 6'($urandom);
        for (int p = 0; p < 5; p++)
        begin
            set_source(sources[p]);
            use_gaps = (p != 2);
            for (int i = 0; i < 91; i++)
                send(random_request());
            send(make(ReqCompute, 6'd0, 6'd0, 16'd0, 6'd0));
            for (int n = 0; n < 16; n++)
                send(make(ReqRead, 6'($urandom), 6'($urandom), 16'($urandom), 6'(n)));
        end

        // duplicate insert, delete of a known edge, then a fresh compute
        use_gaps = 1;
        send(make(ReqLoad, 6'd3, 6'd4, 16'd1, 6'd0));
        send(make(ReqInsert, 6'd62, 6'd61, 16'd1, 6'd0));
        send(make(ReqRead, 6'd0, 6'd0, 16'd0, 6'd61));
        send(make(ReqInsert, sb.slot_tail[0], sb.slot_head[0], 16'd1, 6'd0));
        send(make(ReqDelete, sb.slot_tail[5], sb.slot_head[5], 16'd0, 6'd0));
        send(make(ReqInsert, 6'd62, 6'd61, 16'd7, 6'd0));
        send(make(ReqCompute, 6'd0, 6'd0, 16'd0, 6'd0));
        for (int n = 0; n < 64; n += 7)
            send(make(ReqRead, 6'd0, 6'd0, 16'd0, 6'(n)));

        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("%0d requests issued, %0d results checked, %0d table-full and %0d duplicate",
                 sb.items, sb.results, sb.full_hits, sb.exist_hits);
        $display("load, insert, delete, compute and read requests under six source settings");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("dynamic_graph_shortest_paths test passed");
        else
            $display("dynamic_graph_shortest_paths test failed");
        $finish;
    end

    initial
    begin
        #800000000;
        $display("dynamic_graph_shortest_paths test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/dgsp_pkg.sv
rtl/core/dgsp_ram.sv
rtl/core/dynamic_graph_shortest_paths.sv
dv/tb_dynamic_graph_shortest_paths.sv
